FILE: design/packed_space_card_decoder_unit_assert.svh
// Assertion macros shared by the packed space card decoder modules.
`ifndef PACKED_SPACE_CARD_DECODER_UNIT_ASSERT_SVH
`define PACKED_SPACE_CARD_DECODER_UNIT_ASSERT_SVH

// Plain property on clk_i, off while rst_ni is low.
`define PSCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication on clk_i, off while rst_ni is low.
`define PSCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/pscd_pkg.sv
// Package: constants, item kinds and item types of the packed space card decoder.
package pscd_pkg;

  localparam int unsigned WORDS_PER_CARD = 14;  // 1..15
  localparam int unsigned BYTES_PER_WORD = 6;   // 1..8
  localparam int unsigned RES_DEPTH      = 4;   // result queue entries, at least 2

  localparam logic [7:0]  BYTE_NL      = 8'o012;
  localparam logic [7:0]  BYTE_SPACE   = 8'o040;
  localparam logic [7:0]  BYTE_PRT_LO  = 8'o041;
  localparam logic [7:0]  BYTE_PRT_HI  = 8'o177;
  localparam logic [7:0]  BYTE_PACK_LO = 8'o201;
  localparam logic [7:0]  BYTE_PACK_HI = 8'o323;
  localparam logic [12:0] RUN_MAX      = 13'h1FFF;

  typedef enum logic [2:0] {
    KIND_CHAR = 3'd0,
    KIND_RUN  = 3'd1,
    KIND_EOC  = 3'd2,
    KIND_BAD  = 3'd3,
    KIND_LONG = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [6:0]  code;
    logic [12:0] run;
    logic        last;
  } pscd_item_t;

  // Items produced by one decoded byte.
  typedef struct packed {
    logic [1:0] n;
    pscd_item_t item0;
    pscd_item_t item1;
  } pscd_push_t;

endpackage

FILE: design/pscd_decode.sv
// Byte decoder: card position, pending space count, error flag and item generation.
`include "packed_space_card_decoder_unit_assert.svh"

module pscd_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         byte_i,
  output pscd_pkg::pscd_push_t push_o
);
  import pscd_pkg::*;

  localparam logic [2:0] BIW_LAST = 3'(BYTES_PER_WORD - 1);
  localparam logic [3:0] WPC      = 4'(WORDS_PER_CARD);

  logic [2:0]  biw_q, biw_d;
  logic [3:0]  wic_q, wic_d;
  logic [12:0] pend_q, pend_d;
  logic        skip_q, skip_d;
  logic        halted_q, halted_d;

  logic is_nl, is_space, is_pack, is_prt;
  logic have_run, have_char, have_eoc, have_bad, have_long;

  function automatic logic [12:0] sat_add(logic [12:0] p, logic [6:0] a);
    logic [13:0] sum;
    sum = {1'b0, p} + {7'b0, a};
    return sum[13] ? RUN_MAX : sum[12:0];
  endfunction

  assign is_nl    = (byte_i == BYTE_NL);
  assign is_space = (byte_i == BYTE_SPACE);
  assign is_pack  = (byte_i >= BYTE_PACK_LO) && (byte_i <= BYTE_PACK_HI);
  assign is_prt   = (byte_i >= BYTE_PRT_LO) && (byte_i <= BYTE_PRT_HI);

  always_comb begin
    biw_d     = biw_q;
    wic_d     = wic_q;
    pend_d    = pend_q;
    skip_d    = skip_q;
    halted_d  = halted_q;
    have_run  = 1'b0;
    have_char = 1'b0;
    have_eoc  = 1'b0;
    have_bad  = 1'b0;
    have_long = 1'b0;
    if (fire_i && !halted_q) begin
      if (biw_q == 3'd0 && wic_q >= WPC) begin
        have_long = 1'b1;
        halted_d  = 1'b1;
      end else begin
        if (!skip_q) begin
          if (is_nl) begin
            skip_d = 1'b1;
          end else if (is_pack) begin
            pend_d = sat_add(pend_q, byte_i[6:0]);  // byte minus 0200
          end else if (is_space) begin
            pend_d = sat_add(pend_q, 7'd1);
          end else if (is_prt) begin
            have_run  = (pend_q != 13'd0);
            have_char = 1'b1;
            pend_d    = 13'd0;
          end else begin
            have_bad = 1'b1;
            halted_d = 1'b1;
          end
        end
        if (!have_bad) begin
          if (biw_q >= BIW_LAST) begin
            if (is_nl) begin
              have_eoc = 1'b1;
              biw_d    = 3'd0;
              wic_d    = 4'd0;
              pend_d   = 13'd0;
              skip_d   = 1'b0;
            end else begin
              biw_d = 3'd0;
              if (wic_q != 4'hF) begin
                wic_d = wic_q + 4'd1;
              end
            end
          end else begin
            biw_d = biw_q + 3'd1;
          end
        end
      end
    end
  end

  always_comb begin
    push_o = '0;
    if (have_run) begin
      push_o.n          = 2'd2;
      push_o.item0.kind = KIND_RUN;
      push_o.item0.run  = pend_q;
      push_o.item1.kind = KIND_CHAR;
      push_o.item1.code = byte_i[6:0];
      push_o.item1.last = 1'b1;
    end else if (have_char) begin
      push_o.n          = 2'd1;
      push_o.item0.kind = KIND_CHAR;
      push_o.item0.code = byte_i[6:0];
      push_o.item0.last = 1'b1;
    end else if (have_eoc || have_bad || have_long) begin
      push_o.n          = 2'd1;
      push_o.item0.kind = have_eoc ? KIND_EOC : (have_bad ? KIND_BAD : KIND_LONG);
      push_o.item0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biw_q    <= 3'd0;
      wic_q    <= 4'd0;
      pend_q   <= 13'd0;
      skip_q   <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      biw_q    <= biw_d;
      wic_q    <= wic_d;
      pend_q   <= pend_d;
      skip_q   <= skip_d;
      halted_q <= halted_d;
    end
  end

  `PSCD_ASSERT(a_halt_sticky, halted_q |=> halted_q, "error flag cleared without reset")
  `PSCD_ASSERT_IMP(a_halt_silent, halted_q, push_o.n == 2'd0, "item produced after an error")
  `PSCD_ASSERT(a_biw_range, 4'(biw_q) < 4'(BYTES_PER_WORD), "byte position left its word")

endmodule

FILE: design/pscd_res_fifo.sv
// Result queue: takes up to two items a cycle from the decoder, hands out one.
`include "packed_space_card_decoder_unit_assert.svh"

module pscd_res_fifo #(
  parameter int unsigned DEPTH = pscd_pkg::RES_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pscd_pkg::pscd_push_t push_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pscd_pkg::pscd_item_t head_o
);
  import pscd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  pscd_item_t    mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CW-1:0] count_q, count_d;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  assign wr_nx       = ptr_inc(wr_q);
  assign out_valid_o = (count_q != '0);
  assign head_o      = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room for a two-item byte, judged on the registered count only.
  assign space_o     = (count_q <= CW'(DEPTH - 2));

  always_comb begin
    case (push_i.n)
      2'd1:    wr_d = wr_nx;
      2'd2:    wr_d = ptr_inc(wr_nx);
      default: wr_d = wr_q;
    endcase
    rd_d    = pop ? ptr_inc(rd_q) : rd_q;
    count_d = count_q + CW'(push_i.n) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.item0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_nx] <= push_i.item1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  `PSCD_ASSERT(a_count_max, count_q <= CW'(DEPTH), "queue count beyond depth")
  `PSCD_ASSERT_IMP(a_no_overflow, push_i.n != 2'd0,
    (CW+1)'(count_q) + (CW+1)'(push_i.n) <= (CW+1)'(DEPTH), "queue overflow")
  `PSCD_ASSERT(a_pop_only, pop && push_i.n == 2'd0 |=> count_q == $past(count_q) - CW'(1),
    "count wrong after a pop")

endmodule

FILE: design/packed_space_card_decoder_unit.sv
// Top level of the packed space card decoder: input register, decoder, result queue.
//
// Input channel (in_valid_i / in_ready_o, byte_value_i): one raw card byte per item.
// Output channel (out_valid_o / out_ready_i): one result item per handshake with
// item_kind_o, char_code_o, run_length_o and last_of_input_o. A byte gives zero,
// one or two items; last_of_input_o marks the final item of a byte.
// Spaces (plain or packed 0201..0323) are counted and come out as one space-run
// item just before the next printable character; trailing spaces are dropped.
// A bad byte or an overlong card gives one error item, after which every byte is
// swallowed without results until reset.
// An accepted byte is held in the input register, decoded once the result queue has
// room for two items, and its items are written into the queue before being offered.
// Throughput: one byte per cycle while the queue has room; a byte giving two items
// needs two output handshakes, so the output port paces space-run/character pairs.
// A stalled receiver fills the result queue (RES_DEPTH items); the input register
// holds its byte while fewer than two queue entries are free, and in_ready_o drops
// once that register is full. in_ready_o never depends on out_ready_i.
// Reset (rst_ni low, asynchronous) empties the queue and input register, clears
// the card position, pending space count and error flag.
module packed_space_card_decoder_unit #(
  parameter int unsigned RES_DEPTH = pscd_pkg::RES_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  item_kind_o,
  output logic [6:0]  char_code_o,
  output logic [12:0] run_length_o,
  output logic        last_of_input_o
);
  import pscd_pkg::*;

  // Input register stage
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       space;
  logic       consume;
  pscd_push_t push;
  pscd_item_t head;

  assign consume    = in_valid_q && space;
  assign in_ready_o = !in_valid_q || space;

  always_comb begin
    in_valid_d = in_valid_q;
    if (consume) begin
      in_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload register, loaded on acceptance only
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= byte_value_i;
    end
  end

  pscd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (consume),
    .byte_i (in_byte_q),
    .push_o (push)
  );

  pscd_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign item_kind_o     = head.kind;
  assign char_code_o     = head.code;
  assign run_length_o    = head.run;
  assign last_of_input_o = head.last;

endmodule
